// ===== hw/rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared types, status codes and the character map used by the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Status reported on the transaction that closes a string.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_PAD  = 2'd2,
        ST_BAD_LEN  = 2'd3
    } t_status;

    // ASCII code of the padding character '='.
    localparam logic [7:0] PAD_CODE = 8'd61;

    // Offsets of the alphabet ranges inside the sextet space.
    localparam logic [5:0] LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_BASE = 6'd52;
    localparam logic [5:0] PLUS_VAL   = 6'd62;
    localparam logic [5:0] SLASH_VAL  = 6'd63;

    // Result of looking up one character in the base64 alphabet.
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_map;

    // One group of results caused by a single input item.
    typedef struct packed {
        logic [2:0][7:0] data;       // bytes in output order, entry 0 first
        logic [1:0]      count;      // number of results, 1 to 3
        logic            byte_valid; // results carry decoded bytes
        logic            done;       // last result closes the string
        t_status         status;     // status on the closing result
    } t_run;

    // Maps an ASCII code to its sextet.
    function automatic t_map map_sextet(input logic [7:0] ch);
        t_map m;
        m.ok  = 1'b1;
        m.val = '0;
        priority if (ch >= 8'd65 && ch <= 8'd90) begin
            m.val = 6'(ch - 8'd65);
        end else if (ch >= 8'd97 && ch <= 8'd122) begin
            m.val = 6'(ch - 8'd97) + LOWER_BASE;
        end else if (ch >= 8'd48 && ch <= 8'd57) begin
            m.val = 6'(ch - 8'd48) + DIGIT_BASE;
        end else if (ch == 8'd43) begin
            m.val = PLUS_VAL;
        end else if (ch == 8'd47) begin
            m.val = SLASH_VAL;
        end else begin
            m.ok = 1'b0;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/b64d_in_if.sv =====
// ----------------------------------------------------------------------------
// Base64 decoder input channel
// Valid/ready channel that carries one text character per transaction.
// ----------------------------------------------------------------------------
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_final;

    modport source (output valid, output char_code, output is_final, input ready);
    modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

// ===== hw/rtl/b64d_out_if.sv =====
// ----------------------------------------------------------------------------
// Base64 decoder output channel
// Valid/ready channel that carries one decoded result per transaction.
// ----------------------------------------------------------------------------
interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_end;
    logic       string_done;
    logic [1:0] status;

    modport source (
        output valid, output data_byte, output byte_valid, output run_end,
        output string_done, output status, input ready
    );
    modport sink (
        input valid, input data_byte, input byte_valid, input run_end,
        input string_done, input status, output ready
    );
endinterface

// ===== hw/rtl/base64_stream_decoder_core.sv =====
// Output: the results of a character are registered into the run queue and offered from its head.
// Throughput: one character per cycle while the two-entry result queue has room;
// a group end drains its up to three bytes at one result per cycle on the output port while it is ready.
// Reset: synchronous, active low; clears the group state, the latched error and the queue.
// ----------------------------------------------------------------------------
// Base64 stream decoder core
// Decodes base64 text one character per transaction into bytes and a final
// status per string.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64d_in_if.sink           i_in,
    b64d_out_if.source        o_out
);

    // ------------------------------------------------------------------------
    // Group state. The position counts characters within the current group of
    // four; the sextets of the first three characters wait here until the
    // fourth one arrives. The first error of a string is latched and blocks
    // further decoding, but the position keeps counting so that the length
    // check at the final character still works.
    // ------------------------------------------------------------------------
    logic [1:0]        r_pos,  n_pos;
    logic [5:0]        r_s0,   n_s0;
    logic [5:0]        r_s1,   n_s1;
    logic [5:0]        r_s2,   n_s2;
    logic              r_tpad, n_tpad;
    b64d_pkg::t_status r_err,  n_err;

    // ------------------------------------------------------------------------
    // Result queue. Every input transaction that causes results pushes one run
    // entry, holding all of its results; the output side walks through the
    // run one result per transaction with a sub index.
    // ------------------------------------------------------------------------
    b64d_pkg::t_run    r_run [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic [1:0]        r_sub;

    b64d_pkg::t_run    run;
    b64d_pkg::t_run    head;
    b64d_pkg::t_map    m;
    b64d_pkg::t_status fin_status;
    logic              pad;
    logic              push;
    logic              pop;
    logic              in_fire;
    logic              out_fire;
    logic              last_of_run;
    logic [1:0]        nbytes;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    // The queue takes a new character whenever a run slot is free, so input
    // keeps flowing while a finished result waits at the output.
    assign i_in.ready = (r_count != 2'd2);

    // ------------------------------------------------------------------------
    // Per-character decode: alphabet lookup, padding rules and byte assembly.
    // ------------------------------------------------------------------------
    always_comb begin
        m      = b64d_pkg::map_sextet(i_in.char_code);
        pad    = (i_in.char_code == b64d_pkg::PAD_CODE);
        n_pos  = r_pos;
        n_s0   = r_s0;
        n_s1   = r_s1;
        n_s2   = r_s2;
        n_tpad = r_tpad;
        n_err  = r_err;
        nbytes = 2'd0;

        run.data[0]    = {r_s0, r_s1[5:4]};
        run.data[1]    = {r_s1[3:0], r_s2[5:2]};
        run.data[2]    = {r_s2[1:0], (pad ? 6'd0 : m.val)};
        run.count      = 2'd1;
        run.byte_valid = 1'b1;
        run.done       = 1'b0;
        run.status     = b64d_pkg::ST_OK;
        push           = 1'b0;
        fin_status     = b64d_pkg::ST_OK;

        if (r_err == b64d_pkg::ST_OK) begin
            unique case (r_pos)
                2'd0, 2'd1: begin
                    priority if (pad) begin
                        n_err = b64d_pkg::ST_BAD_PAD;
                    end else if (!m.ok) begin
                        n_err = b64d_pkg::ST_BAD_CHAR;
                    end else if (r_pos == 2'd0) begin
                        n_s0 = m.val;
                    end else begin
                        n_s1 = m.val;
                    end
                end
                2'd2: begin
                    priority if (pad) begin
                        n_tpad = 1'b1;
                        n_s2   = '0;
                    end else if (!m.ok) begin
                        n_err = b64d_pkg::ST_BAD_CHAR;
                    end else begin
                        n_tpad = 1'b0;
                        n_s2   = m.val;
                    end
                end
                default: begin
                    // Fourth character: a padded group is legal only at the
                    // end of the string, and a padded third needs a padded
                    // fourth.
                    priority if (!pad && !m.ok) begin
                        n_err = b64d_pkg::ST_BAD_CHAR;
                    end else if (r_tpad && !pad) begin
                        n_err = b64d_pkg::ST_BAD_PAD;
                    end else if ((r_tpad || pad) && !i_in.is_final) begin
                        n_err = b64d_pkg::ST_BAD_PAD;
                    end else if (r_tpad) begin
                        nbytes = 2'd1;
                    end else if (pad) begin
                        nbytes = 2'd2;
                    end else begin
                        nbytes = 2'd3;
                    end
                end
            endcase
        end

        if (i_in.is_final) begin
            // Length takes precedence over any other error.
            fin_status = (r_pos != 2'd3) ? b64d_pkg::ST_BAD_LEN : n_err;
            push       = 1'b1;
            run.done   = 1'b1;
            if (fin_status != b64d_pkg::ST_OK || nbytes == 2'd0) begin
                run.data       = '0;
                run.count      = 2'd1;
                run.byte_valid = 1'b0;
                run.status     = fin_status;
            end else begin
                run.count = nbytes;
            end
            // The string is closed: back to the reset state.
            n_pos  = 2'd0;
            n_s0   = '0;
            n_s1   = '0;
            n_s2   = '0;
            n_tpad = 1'b0;
            n_err  = b64d_pkg::ST_OK;
        end else begin
            push      = (nbytes != 2'd0);
            run.count = nbytes;
            n_pos     = r_pos + 2'd1;
            if (r_pos == 2'd3) begin
                n_tpad = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: the head run is presented one result at a time.
    // ------------------------------------------------------------------------
    always_comb begin
        head        = r_run[r_rd_ptr];
        last_of_run = (r_sub == head.count - 2'd1);
        pop         = out_fire && last_of_run;

        o_out.valid       = (r_count != 2'd0);
        o_out.data_byte   = head.byte_valid ? head.data[r_sub] : 8'd0;
        o_out.byte_valid  = head.byte_valid;
        o_out.run_end     = last_of_run;
        o_out.string_done = head.done && last_of_run;
        o_out.status      = (head.done && last_of_run) ? head.status : b64d_pkg::ST_OK;
    end

    // Run storage holds payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire && push) begin
            r_run[r_wr_ptr] <= run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 2'd0;
            r_s0     <= '0;
            r_s1     <= '0;
            r_s2     <= '0;
            r_tpad   <= 1'b0;
            r_err    <= b64d_pkg::ST_OK;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 2'd0;
        end else begin
            if (in_fire) begin
                r_pos  <= n_pos;
                r_s0   <= n_s0;
                r_s1   <= n_s1;
                r_s2   <= n_s2;
                r_tpad <= n_tpad;
                r_err  <= n_err;
                if (push) begin
                    r_wr_ptr <= ~r_wr_ptr;
                end
            end

            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_sub    <= 2'd0;
            end else if (out_fire) begin
                r_sub <= r_sub + 2'd1;
            end

            unique case ({in_fire && push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Feeds base64 strings one character per transaction into the decoder. A
// decoder model inside the bench predicts the bytes and the closing status
// of every string. A checker compares each result field by field with the
// oldest prediction. Both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic [7:0] t_text[$];

    // One predicted output transaction.
    typedef struct {
        logic [7:0]          data;
        logic                bval;
        logic                last;
        logic                done;
        b64d_pkg::t_status   status;
    } t_decoded;

    // Ways in which a random string gets broken.
    typedef enum int {
        FLAW_BYTE  = 0,   // one character replaced by an arbitrary byte
        FLAW_PAD   = 1,   // one character replaced by padding
        FLAW_SHORT = 2,   // string cut short of a group boundary
        FLAW_LONG  = 3    // extra characters after the last group
    } t_flaw;

    logic i_clk;
    logic i_rst_n;

    b64d_in_if  in_if ();
    b64d_out_if out_if ();

    base64_stream_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Decoder model state.
    logic [1:0]        grp_pos;
    logic [5:0]        sx_first;
    logic [5:0]        sx_second;
    logic [5:0]        sx_third;
    logic              third_pad;
    b64d_pkg::t_status latched_err;

    t_decoded decoded_q[$];

    int  fail_count  = 0;
    int  result_idx  = 0;
    bit  in_idle_en  = 1'b1;
    bit  out_idle_en = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic bit lookup_sextet(input logic [7:0] c, output logic [5:0] v);
        v = '0;
        if (c >= 8'd65 && c <= 8'd90) begin
            v = 6'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            v = 6'(c - 8'd97) + b64d_pkg::LOWER_BASE;
        end else if (c >= 8'd48 && c <= 8'd57) begin
            v = 6'(c - 8'd48) + b64d_pkg::DIGIT_BASE;
        end else if (c == 8'd43) begin
            v = b64d_pkg::PLUS_VAL;
        end else if (c == 8'd47) begin
            v = b64d_pkg::SLASH_VAL;
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26) begin
            return 8'd65 + 8'(v);
        end else if (v < 6'd52) begin
            return 8'd97 + 8'(v - 6'd26);
        end else if (v < 6'd62) begin
            return 8'd48 + 8'(v - 6'd52);
        end else if (v == 6'd62) begin
            return 8'd43;
        end
        return 8'd47;
    endfunction

    function automatic void clear_decoder();
        grp_pos     = '0;
        sx_first    = '0;
        sx_second   = '0;
        sx_third    = '0;
        third_pad   = 1'b0;
        latched_err = b64d_pkg::ST_OK;
    endfunction

    function automatic void push_result(input logic [7:0] d, input logic bv,
                                        input logic last, input logic done,
                                        input b64d_pkg::t_status st);
        t_decoded r;
        r.data   = d;
        r.bval   = bv;
        r.last   = last;
        r.done   = done;
        r.status = st;
        decoded_q.insert(decoded_q.size(), r);
    endfunction

    // Advances the model by one accepted character and queues its results.
    function automatic void decode_char(input logic [7:0] c, input logic fin);
        logic [5:0]        v;
        logic [5:0]        d;
        logic [7:0]        b[3];
        logic [1:0]        pos;
        bit                ok;
        bit                pad;
        int                nb;
        b64d_pkg::t_status st;

        pos = grp_pos;
        ok  = lookup_sextet(c, v);
        pad = (c == b64d_pkg::PAD_CODE);
        nb  = 0;

        if (latched_err == b64d_pkg::ST_OK) begin
            case (pos)
                2'd0, 2'd1: begin
                    if (pad) begin
                        latched_err = b64d_pkg::ST_BAD_PAD;
                    end else if (!ok) begin
                        latched_err = b64d_pkg::ST_BAD_CHAR;
                    end else if (pos == 2'd0) begin
                        sx_first = v;
                    end else begin
                        sx_second = v;
                    end
                end
                2'd2: begin
                    if (pad) begin
                        third_pad = 1'b1;
                        sx_third  = '0;
                    end else if (!ok) begin
                        latched_err = b64d_pkg::ST_BAD_CHAR;
                    end else begin
                        third_pad = 1'b0;
                        sx_third  = v;
                    end
                end
                default: begin
                    if (!pad && !ok) begin
                        latched_err = b64d_pkg::ST_BAD_CHAR;
                    end else if (third_pad && !pad) begin
                        latched_err = b64d_pkg::ST_BAD_PAD;
                    end else if ((third_pad || pad) && !fin) begin
                        // Padding is only allowed in the group that ends the string.
                        latched_err = b64d_pkg::ST_BAD_PAD;
                    end else begin
                        d = pad ? 6'd0 : v;
                        b[nb++] = {sx_first, sx_second[5:4]};
                        if (!third_pad) begin
                            b[nb++] = {sx_second[3:0], sx_third[5:2]};
                        end
                        if (!pad) begin
                            b[nb++] = {sx_third[1:0], d};
                        end
                    end
                end
            endcase
        end

        if (fin) begin
            // A bad length wins over every other error.
            st = (pos != 2'd3) ? b64d_pkg::ST_BAD_LEN : latched_err;
            if (st != b64d_pkg::ST_OK || nb == 0) begin
                push_result(8'd0, 1'b0, 1'b1, 1'b1, st);
            end else begin
                for (int i = 0; i < nb; i++) begin
                    push_result(b[i], 1'b1, i == nb - 1, i == nb - 1, b64d_pkg::ST_OK);
                end
            end
            clear_decoder();
        end else begin
            for (int i = 0; i < nb; i++) begin
                push_result(b[i], 1'b1, i == nb - 1, 1'b0, b64d_pkg::ST_OK);
            end
            grp_pos = pos + 2'd1;
            if (grp_pos == 2'd0) begin
                third_pad = 1'b0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Valid stays high across back-to-back characters; it only drops for a gap.
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.char_code <= c;
        in_if.is_final  <= fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        decode_char(c, fin);
    endtask

    task automatic send_text(input t_text t);
        for (int i = 0; i < t.size(); i++) begin
            send_char(t[i], i == t.size() - 1);
        end
    endtask

    function automatic t_text str_to_text(input string s);
        t_text t;
        for (int i = 0; i < s.len(); i++) begin
            t.insert(t.size(), s[i]);
        end
        return t;
    endfunction

    // Clean groups of random sextets, the last group padded by zero to two.
    function automatic t_text random_groups(input int ngrp);
        t_text t;
        int    npad;
        for (int g = 0; g < 4 * ngrp; g++) begin
            t.insert(t.size(), sextet_char(6'($urandom_range(0, 63))));
        end
        npad = $urandom_range(0, 2);
        if (npad >= 1) begin
            t[t.size() - 1] = b64d_pkg::PAD_CODE;
        end
        if (npad == 2) begin
            t[t.size() - 2] = b64d_pkg::PAD_CODE;
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    initial begin
        int n;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_idle_en && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 10);
                out_if.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_decoded e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          result_idx));
            end else begin
                e = decoded_q.pop_front();
                if (out_if.data_byte !== e.data)
                    report_mismatch($sformatf("result %0d data_byte %02h, want %02h",
                                              result_idx, out_if.data_byte, e.data));
                if (out_if.byte_valid !== e.bval)
                    report_mismatch($sformatf("result %0d byte_valid %b, want %b",
                                              result_idx, out_if.byte_valid, e.bval));
                if (out_if.run_end !== e.last)
                    report_mismatch($sformatf("result %0d run_end %b, want %b",
                                              result_idx, out_if.run_end, e.last));
                if (out_if.string_done !== e.done)
                    report_mismatch($sformatf("result %0d string_done %b, want %b",
                                              result_idx, out_if.string_done, e.done));
                if (out_if.status !== e.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              result_idx, out_if.status, e.status));
            end
            result_idx++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Both ends of every alphabet range, the second group closing the string.
    task automatic test_alphabet();
        send_text(str_to_text("AZaz09+/"));
    endtask

    // One and two padding characters, and nonzero bits dropped by padding.
    task automatic test_padding();
        send_text(str_to_text("QR=="));
        send_text(str_to_text("QUI="));
    endtask

    task automatic test_errors();
        t_text t;
        // Bad fourth character after a padded third.
        send_text(str_to_text("QQ=*"));
        // Padding in the first position, string also too short.
        send_text(str_to_text("="));
        // Bad second character with the top code, then a short length.
        t = str_to_text("Q");
        t.insert(t.size(), 8'hFF);
        t.insert(t.size(), 8'd65);
        send_text(t);
    endtask

    // Mostly well-formed strings, about a third of them broken in some way.
    task automatic test_random_strings(input int budget);
        t_text t;
        int    items;
        int    ngrp;
        t_flaw flaw;
        items = 0;
        while (items < budget) begin
            ngrp = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
            t = random_groups(ngrp);
            if ($urandom_range(0, 9) < 3) begin
                flaw = t_flaw'($urandom_range(0, 3));
                case (flaw)
                    FLAW_BYTE: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
                    FLAW_PAD:  t[$urandom_range(0, t.size() - 1)] = b64d_pkg::PAD_CODE;
                    FLAW_SHORT: begin
                        repeat ($urandom_range(1, 3)) t.pop_back();
                    end
                    default: begin
                        repeat ($urandom_range(1, 3)) begin
                            t.insert(t.size(), sextet_char(6'($urandom_range(0, 63))));
                        end
                    end
                endcase
            end
            send_text(t);
            items += t.size();
        end
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_back_to_back();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        repeat (8) send_text(random_groups($urandom_range(1, 2)));
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.char_code  <= 8'd0;
        in_if.is_final   <= 1'b0;
        clear_decoder();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_alphabet();
        test_padding();
        test_errors();
        test_random_strings(190);
        test_back_to_back();
        wait_drained();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
